// ----- rtl/core/cnh_pkg.sv -----
// Shared types and constants for the circulant next-hop router.
// No dependencies; every other file imports this package.
package cnh_pkg;

    localparam int MAX_NODES = 1024;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int RING_W    = NODE_W + 1;
    localparam int STEP_W    = NODE_W;
    localparam int DIV_BITS  = NODE_W + 3;     // |dividend| < 3 * 2^RING_W fits 13 bits
    localparam int DD_W      = DIV_BITS + 2;   // signed dividend width
    localparam int COST_W    = DIV_BITS + 3;
    localparam int RES_W     = NODE_W + 3;
    localparam int NUM_LANES = 6;              // forward k=0..2, backward k=0..2
    localparam int PADDR_W   = 4;

    typedef enum logic [1:0] {
        REG_RING_NODES = 2'd0,
        REG_SHORT_STEP = 2'd1,
        REG_LONG_STEP  = 2'd2,
        REG_NONE       = 2'd3
    } cnh_reg_t;

    typedef struct packed {
        logic                neg;
        logic [DIV_BITS-1:0] num;
        logic [STEP_W-1:0]   rem;
        logic [DIV_BITS-1:0] quo;
    } cnh_lane_t;

    typedef struct packed {
        logic [NODE_W-1:0] here;
        logic              eq;
        logic              bypass;
        logic              swapped;
    } cnh_side_t;

    typedef struct packed {
        logic signed [COST_W-1:0] a;
        logic signed [COST_W-1:0] b;
        logic                     rz;
    } cnh_cost_t;

    typedef struct packed {
        logic signed [COST_W-1:0] best_f;
        logic                     long_f;
        logic signed [COST_W-1:0] best_b;
        logic                     long_b;
    } cnh_sel_t;

endpackage

// ----- rtl/core/cnh_if.sv -----
// Valid/ready channel interfaces for requests and responses.
// Depends on cnh_pkg.
interface cnh_req_if import cnh_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] here_node;
    logic [NODE_W-1:0] target_node;
    modport source (output valid, output here_node, output target_node, input ready);
    modport sink   (input valid, input here_node, input target_node, output ready);
endinterface

interface cnh_rsp_if import cnh_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] next_node;
    logic              deliver_local;
    modport source (output valid, output next_node, output deliver_local, input ready);
    modport sink   (input valid, input next_node, input deliver_local, output ready);
endinterface

// ----- rtl/core/circulant_adaptive_next_hop.sv -----
// Top level of the circulant next-hop router: APB registers and pipeline.
// Depends on cnh_pkg, cnh_if, cnh_front, cnh_div_stage, cnh_cost, cnh_select.
//
//  channel | dir | payload                      | accepted when
//  --------+-----+------------------------------+---------------------------
//  req     | in  | here_node, target_node       | req.valid && req.ready
//  rsp     | out | next_node, deliver_local     | rsp.valid && rsp.ready
//  apb     | in  | ring_nodes/short/long_step   | psel && penable && pwrite
//
//  Stages: front, 13 division stages (one quotient bit per stage for six
//  dividends in parallel), cost, select and the output register. One
//  transaction per cycle is sustained while rsp does not stall.
//  Reset clears only the valid bits and loads register defaults (16, 1, 4).
//  A stall on rsp freezes every stage at once; req.ready drops for as long
//  as the output register holds an untaken result.
module circulant_adaptive_next_hop
    import cnh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    cnh_req_if.sink            req,
    cnh_rsp_if.source          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    // ---------------- configuration registers ----------------
    logic [RING_W-1:0] ring_nodes_reg;
    logic [STEP_W-1:0] short_step_reg;
    logic [STEP_W-1:0] long_step_reg;
    cnh_reg_t          reg_sel;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_sel = cnh_reg_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_nodes_reg <= RING_W'(16);
            short_step_reg <= STEP_W'(1);
            long_step_reg  <= STEP_W'(4);
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_RING_NODES: ring_nodes_reg <= pwdata[RING_W-1:0];
                REG_SHORT_STEP: short_step_reg <= pwdata[STEP_W-1:0];
                REG_LONG_STEP:  long_step_reg  <= pwdata[STEP_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_RING_NODES: prdata = 32'(ring_nodes_reg);
            REG_SHORT_STEP: prdata = 32'(short_step_reg);
            REG_LONG_STEP:  prdata = 32'(long_step_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- pipeline ----------------
    logic out_valid_reg;
    logic en;

    // whole pipe advances together; it moves whenever the output slot frees
    assign en        = !out_valid_reg || rsp.ready;
    assign req.ready = en;

    logic                      vld_w   [DIV_BITS+1];
    cnh_side_t                 side_w  [DIV_BITS+1];
    cnh_lane_t [NUM_LANES-1:0] lanes_w [DIV_BITS+1];

    cnh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req.valid),
        .here      (req.here_node),
        .dest      (req.target_node),
        .ring      (ring_nodes_reg),
        .long_step (long_step_reg),
        .out_valid (vld_w[0]),
        .side_out  (side_w[0]),
        .lanes_out (lanes_w[0])
    );

    for (genvar s = 0; s < DIV_BITS; s++)
    begin : g_div
        cnh_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .divisor   (long_step_reg),
            .in_valid  (vld_w[s]),
            .side_in   (side_w[s]),
            .lanes_in  (lanes_w[s]),
            .out_valid (vld_w[s+1]),
            .side_out  (side_w[s+1]),
            .lanes_out (lanes_w[s+1])
        );
    end

    logic                      cost_vld;
    cnh_side_t                 cost_side;
    cnh_cost_t [NUM_LANES-1:0] cost_w;

    cnh_cost u_cost (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .long_step (long_step_reg),
        .in_valid  (vld_w[DIV_BITS]),
        .side_in   (side_w[DIV_BITS]),
        .lanes_in  (lanes_w[DIV_BITS]),
        .out_valid (cost_vld),
        .side_out  (cost_side),
        .cost_out  (cost_w)
    );

    logic      sel_vld;
    cnh_side_t sel_side;
    cnh_sel_t  sel_w;

    cnh_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cost_vld),
        .side_in   (cost_side),
        .cost_in   (cost_w),
        .out_valid (sel_vld),
        .side_out  (sel_side),
        .sel_out   (sel_w)
    );

    // ---------------- final step and wrap ----------------
    logic [NODE_W-1:0] next_node_reg;
    logic              deliver_reg;
    logic [NODE_W-1:0] next_node_next;

    always_comb
    begin
        logic signed [RES_W-1:0] step_f;
        logic signed [RES_W-1:0] step_b;
        logic signed [RES_W-1:0] step;
        logic signed [RES_W-1:0] res;
        logic signed [RES_W-1:0] n_s;
        n_s    = RES_W'(ring_nodes_reg);
        step_f = RES_W'(sel_w.long_f ? long_step_reg : short_step_reg);
        step_b = RES_W'(sel_w.long_b ? long_step_reg : short_step_reg);
        // forward wins only on a strictly lower cost
        step   = (sel_w.best_f < sel_w.best_b) ? step_f : -step_b;
        res    = sel_side.swapped ? RES_W'(sel_side.here) - step
                                  : RES_W'(sel_side.here) + step;
        if (res >= n_s)
            res = res - n_s;
        else if (res < 0)
            res = res + n_s;
        next_node_next = sel_side.bypass ? sel_side.here : res[NODE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= sel_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            next_node_reg <= next_node_next;
            deliver_reg   <= sel_side.eq;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.next_node     = next_node_reg;
    assign rsp.deliver_local = deliver_reg;
endmodule

// ----- rtl/core/cnh_front.sv -----
// Front stage: orders the pair and forms the six signed dividends.
// Depends on cnh_pkg.
module cnh_front
    import cnh_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [NODE_W-1:0]                here,
    input  logic [NODE_W-1:0]                dest,
    input  logic [RING_W-1:0]                ring,
    input  logic [STEP_W-1:0]                long_step,
    output logic                             out_valid,
    output cnh_side_t                        side_out,
    output cnh_lane_t [NUM_LANES-1:0]        lanes_out
);
    logic                      valid_reg;
    cnh_side_t                 side_reg;
    cnh_lane_t [NUM_LANES-1:0] lanes_reg;
    cnh_side_t                 side_next;
    cnh_lane_t [NUM_LANES-1:0] lanes_next;

    always_comb
    begin
        logic [NODE_W-1:0]      lo;
        logic [NODE_W-1:0]      hi;
        logic signed [DD_W-1:0] n_s;
        logic signed [DD_W-1:0] d_f;
        logic signed [DD_W-1:0] d_b;
        logic signed [DD_W-1:0] dd;
        side_next.here    = here;
        side_next.eq      = (here == dest);
        side_next.bypass  = (here == dest) || (long_step == '0);
        side_next.swapped = here > dest;
        lo  = side_next.swapped ? dest : here;
        hi  = side_next.swapped ? here : dest;
        n_s = DD_W'(ring);
        d_f = DD_W'(hi) - DD_W'(lo);
        d_b = DD_W'(lo) - DD_W'(hi) + n_s;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            dd = (i < 3) ? d_f : d_b;
            if (i % 3 == 1)
                dd = dd + n_s;
            else if (i % 3 == 2)
                dd = dd + (n_s <<< 1);
            lanes_next[i].neg = dd[DD_W-1];
            lanes_next[i].num = dd[DD_W-1] ? DIV_BITS'(-dd) : DIV_BITS'(dd);
            lanes_next[i].rem = '0;
            lanes_next[i].quo = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg  <= side_next;
            lanes_reg <= lanes_next;
        end
    end

    assign out_valid = valid_reg;
    assign side_out  = side_reg;
    assign lanes_out = lanes_reg;
endmodule

// ----- rtl/core/cnh_div_stage.sv -----
// One restoring-division stage: one quotient bit for each of the six lanes.
// Depends on cnh_pkg.
module cnh_div_stage
    import cnh_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [STEP_W-1:0]         divisor,
    input  logic                      in_valid,
    input  cnh_side_t                 side_in,
    input  cnh_lane_t [NUM_LANES-1:0] lanes_in,
    output logic                      out_valid,
    output cnh_side_t                 side_out,
    output cnh_lane_t [NUM_LANES-1:0] lanes_out
);
    logic                      valid_reg;
    cnh_side_t                 side_reg;
    cnh_lane_t [NUM_LANES-1:0] lanes_reg;
    cnh_lane_t [NUM_LANES-1:0] lanes_next;

    always_comb
    begin
        logic [STEP_W:0] trial;
        logic [STEP_W:0] dv;
        logic            ge;
        dv = {1'b0, divisor};
        for (int i = 0; i < NUM_LANES; i++)
        begin
            trial = {lanes_in[i].rem, lanes_in[i].num[DIV_BITS-1]};
            ge    = trial >= dv;
            lanes_next[i].neg = lanes_in[i].neg;
            lanes_next[i].num = {lanes_in[i].num[DIV_BITS-2:0], 1'b0};
            lanes_next[i].rem = ge ? STEP_W'(trial - dv) : trial[STEP_W-1:0];
            lanes_next[i].quo = {lanes_in[i].quo[DIV_BITS-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg  <= side_in;
            lanes_reg <= lanes_next;
        end
    end

    assign out_valid = valid_reg;
    assign side_out  = side_reg;
    assign lanes_out = lanes_reg;
endmodule

// ----- rtl/core/cnh_cost.sv -----
// Cost stage: signs the quotient and remainder, forms costs A and B per lane.
// Depends on cnh_pkg.
module cnh_cost
    import cnh_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [STEP_W-1:0]         long_step,
    input  logic                      in_valid,
    input  cnh_side_t                 side_in,
    input  cnh_lane_t [NUM_LANES-1:0] lanes_in,
    output logic                      out_valid,
    output cnh_side_t                 side_out,
    output cnh_cost_t [NUM_LANES-1:0] cost_out
);
    logic                      valid_reg;
    cnh_side_t                 side_reg;
    cnh_cost_t [NUM_LANES-1:0] cost_reg;
    cnh_cost_t [NUM_LANES-1:0] cost_next;

    always_comb
    begin
        logic signed [COST_W-1:0] q;
        logic signed [COST_W-1:0] r;
        logic signed [COST_W-1:0] g;
        g = COST_W'(long_step);
        for (int i = 0; i < NUM_LANES; i++)
        begin
            // truncating division: quotient and remainder take the dividend's sign
            q = COST_W'(lanes_in[i].quo);
            r = COST_W'(lanes_in[i].rem);
            if (lanes_in[i].neg)
            begin
                q = -q;
                r = -r;
            end
            cost_next[i].a  = q + r;
            cost_next[i].b  = q - r + g + COST_W'(1);
            cost_next[i].rz = (lanes_in[i].rem == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_in;
            cost_reg <= cost_next;
        end
    end

    assign out_valid = valid_reg;
    assign side_out  = side_reg;
    assign cost_out  = cost_reg;
endmodule

// ----- rtl/core/cnh_select.sv -----
// Select stage: best cost and step kind for each direction.
// Depends on cnh_pkg.
module cnh_select
    import cnh_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  cnh_side_t                 side_in,
    input  cnh_cost_t [NUM_LANES-1:0] cost_in,
    output logic                      out_valid,
    output cnh_side_t                 side_out,
    output cnh_sel_t                  sel_out
);
    logic      valid_reg;
    cnh_side_t side_reg;
    cnh_sel_t  sel_reg;
    cnh_sel_t  sel_next;

    always_comb
    begin
        logic signed [COST_W-1:0] best [2];
        logic                     lng  [2];
        cnh_cost_t                c;
        for (int d = 0; d < 2; d++)
        begin
            c = cost_in[3*d];
            if (c.rz)
            begin
                best[d] = c.a;
                lng[d]  = 1'b1;
            end
            else if (c.a < c.b)
            begin
                best[d] = c.a;
                lng[d]  = 1'b0;
            end
            else
            begin
                best[d] = c.b;
                lng[d]  = 1'b1;
            end
            for (int k = 1; k < 3; k++)
            begin
                c = cost_in[3*d+k];
                if (c.a < best[d])
                begin
                    best[d] = c.a;
                    lng[d]  = 1'b1;
                end
                if (c.b < best[d])
                begin
                    best[d] = c.b;
                    lng[d]  = 1'b1;
                end
            end
        end
        sel_next.best_f = best[0];
        sel_next.long_f = lng[0];
        sel_next.best_b = best[1];
        sel_next.long_b = lng[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_in;
            sel_reg  <= sel_next;
        end
    end

    assign out_valid = valid_reg;
    assign side_out  = side_reg;
    assign sel_out   = sel_reg;
endmodule

// ----- dv/circulant_adaptive_next_hop_tb.sv -----
// Testbench for circulant_adaptive_next_hop: directed table, then random routing traffic.
// Results are checked against an in-bench next-hop predictor.
// Depends on cnh_pkg, cnh_if and the RTL top level.
`timescale 1ns / 100ps

module circulant_adaptive_next_hop_tb;
    import cnh_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 25;
    localparam int RAND_ITEMS = 2000;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    cnh_req_if req ();
    cnh_rsp_if rsp ();

    circulant_adaptive_next_hop u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req.sink),
        .rsp     (rsp.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Expected hop for each accepted transaction, oldest first
    typedef struct packed {
        logic [NODE_W-1:0] next_node;
        logic              deliver_local;
    } hop_t;

    hop_t hop_queue[$];
    int   failures = 0;
    int   cycles = 0;
    bit   calm_mode = 0;   // no idling on either side while set

    // Register shadow, as the block holds it
    int ring_nodes_q = 16;
    int short_step_q = 1;
    int long_step_q = 4;

    // Directed table
    typedef struct {
        int here;
        int dest;
        bit typed;   // expectation given in the row
        int exp_next;
        bit exp_local;
    } dir_row_t;

    dir_row_t dir_rows[20];

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_mode || roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Cost and step for one direction, distance d, over k = 0..2 ring lengths
    task automatic direction_cost(input int d, output int best, output int step);
        int q;
        int r;
        int a;
        int b;
        int dd;
        q = d / long_step_q;
        r = d % long_step_q;
        a = q + r;
        b = q - r + long_step_q + 1;
        if (r == 0)
        begin
            best = a;
            step = long_step_q;
        end
        else if (a < b)
        begin
            best = a;
            step = short_step_q;
        end
        else
        begin
            best = b;
            step = long_step_q;
        end
        for (int k = 1; k <= 2; k++)
        begin
            dd = d + k * ring_nodes_q;
            q = dd / long_step_q;
            r = dd % long_step_q;
            a = q + r;
            b = q - r + long_step_q + 1;
            if (a < best)
            begin
                best = a;
                step = long_step_q;
            end
            if (b < best)
            begin
                best = b;
                step = long_step_q;
            end
        end
    endtask

    task automatic predict_hop(input int here, input int dest, output hop_t hop);
        int lo;
        int hi;
        int best_fwd;
        int step_fwd;
        int best_bwd;
        int step_bwd;
        int step;
        int res;
        bit swapped;
        if (here == dest || long_step_q == 0)
        begin
            hop.next_node = NODE_W'(here);
            hop.deliver_local = (here == dest);
            return;
        end
        swapped = here > dest;
        lo = swapped ? dest : here;
        hi = swapped ? here : dest;
        direction_cost(hi - lo, best_fwd, step_fwd);
        direction_cost(lo - hi + ring_nodes_q, best_bwd, step_bwd);
        step = (best_fwd < best_bwd) ? step_fwd : -step_bwd;
        res = swapped ? here - step : here + step;
        // single wrap only
        if (res >= ring_nodes_q)
            res -= ring_nodes_q;
        else if (res < 0)
            res += ring_nodes_q;
        hop.next_node = res[NODE_W-1:0];
        hop.deliver_local = 1'b0;
    endtask

    // Register write: setup cycle, then access cycle
    task automatic reg_write(input cnh_reg_t idx, input int value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(int'(idx) * 4);
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_RING_NODES: ring_nodes_q = value & 'h7FF;
            REG_SHORT_STEP: short_step_q = value & 'h3FF;
            REG_LONG_STEP:  long_step_q = value & 'h3FF;
            default: ;
        endcase
    endtask

    task automatic set_config(input int ring, input int short_s, input int long_s);
        reg_write(REG_RING_NODES, ring);
        reg_write(REG_SHORT_STEP, short_s);
        reg_write(REG_LONG_STEP, long_s);
    endtask

    // Offer one transaction; queue its expectation at acceptance.
    // valid stays high into the next transaction when no gap follows.
    task automatic send_hop(input int here, input int dest, input bit typed,
                            input hop_t typed_hop);
        hop_t hop;
        int gap;
        req.valid <= 1'b1;
        req.here_node <= NODE_W'(here);
        req.target_node <= NODE_W'(dest);
        do
            @(posedge clk);
        while (!req.ready);
        if (typed)
            hop = typed_hop;
        else
            predict_hop(here, dest, hop);
        hop_queue = {hop_queue, hop};
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drop_valid();
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until all results are back, then let the pipeline settle
    task automatic drain();
        while (hop_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_traffic(input int count);
        int here;
        int dest;
        int roll;
        int top;
        hop_t none;
        none = '0;
        top = (ring_nodes_q >= 1 && ring_nodes_q <= 1024) ? ring_nodes_q - 1 : 1023;
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                calm_mode = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 65)
            begin
                // in-range pair, the common routing case
                here = $urandom_range(0, top);
                dest = $urandom_range(0, top);
            end
            else if (roll < 75)
            begin
                here = $urandom_range(0, 1023);
                dest = here;
            end
            else
            begin
                // anywhere in the field, out-of-ring nodes included
                here = $urandom_range(0, 1023);
                dest = $urandom_range(0, 1023);
            end
            send_hop(here, dest, 1'b0, none);
        end
        calm_mode = 0;
        drop_valid();
    endtask

    // Response side: random backpressure, check every accepted transaction
    int stall_left = 0;
    always @(posedge clk)
    begin
        hop_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (hop_queue.size() == 0)
            begin
                $error("unexpected response: next_node=%0d deliver_local=%0b",
                       rsp.next_node, rsp.deliver_local);
                failures = failures + 1;
            end
            else
            begin
                want = hop_queue.pop_front();
                if (rsp.next_node !== want.next_node)
                begin
                    $error("next_node: expected %0d, got %0d", want.next_node,
                           rsp.next_node);
                    failures = failures + 1;
                end
                if (rsp.deliver_local !== want.deliver_local)
                begin
                    $error("deliver_local: expected %0b, got %0b", want.deliver_local,
                           rsp.deliver_local);
                    failures = failures + 1;
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp.ready <= 1'b0;
        end
        else
        begin
            stall_left <= pick_gap();
            rsp.ready <= 1'b1;
        end
    end

    initial
    begin
        hop_t typed_hop;
        int phases;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req.valid = 1'b0;
        req.here_node = '0;
        req.target_node = '0;
        rsp.ready = 1'b0;

        // Reset config 16/1/4. Equal nodes deliver locally at here_node.
        dir_rows = '{
            '{0, 0, 1, 0, 1},
            '{1023, 1023, 1, 1023, 1},
            '{5, 5, 1, 5, 1},
            '{0, 15, 0, 0, 0},
            '{15, 0, 0, 0, 0},
            '{0, 1, 0, 0, 0},
            '{1, 0, 0, 0, 0},
            '{0, 4, 0, 0, 0},
            '{4, 0, 0, 0, 0},
            '{0, 8, 0, 0, 0},
            '{3, 11, 0, 0, 0},
            '{0, 12, 0, 0, 0},
            '{12, 0, 0, 0, 0},
            '{7, 9, 0, 0, 0},
            '{9, 7, 0, 0, 0},
            '{0, 1023, 0, 0, 0},   // beyond the ring: negative backward distance
            '{1023, 0, 0, 0, 0},
            '{1023, 512, 0, 0, 0},
            '{20, 3, 0, 0, 0},
            '{682, 341, 0, 0, 0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            typed_hop.next_node = NODE_W'(dir_rows[i].exp_next);
            typed_hop.deliver_local = dir_rows[i].exp_local;
            send_hop(dir_rows[i].here, dir_rows[i].dest, dir_rows[i].typed, typed_hop);
        end
        drop_valid();
        random_traffic(100);
        drain();

        // Fixed settings first (extremes, zero long step, degenerate rings), then random
        phases = 16;
        for (int p = 0; p < phases; p++)
        begin
            case (p)
                0: set_config(1024, 1, 32);
                1: set_config(2, 1, 1);
                2: set_config(1024, 512, 512);
                3: set_config(7, 3, 5);
                4: set_config(16, 1, 0);       // zero long step: no move
                5: set_config(0, 5, 3);        // degenerate ring
                6: set_config(1, 1, 2);
                7: set_config(2047, 1023, 1023);
                8: set_config(100, 0, 10);
                default: set_config($urandom_range(2, 1024), $urandom_range(1, 512),
                                    $urandom_range(1, 512));
            endcase
            random_traffic((RAND_ITEMS - 100) / phases);
            drain();
        end

        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- circulant_adaptive_next_hop.f -----
rtl/core/cnh_pkg.sv
rtl/core/cnh_if.sv
rtl/core/cnh_front.sv
rtl/core/cnh_div_stage.sv
rtl/core/cnh_cost.sv
rtl/core/cnh_select.sv
rtl/core/circulant_adaptive_next_hop.sv
dv/circulant_adaptive_next_hop_tb.sv
